@@ rtl/core/hcmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmd_pkg
// Shared types, constants and arithmetic helpers for the HSV crossfade and
// motion dimmer.
// ----------------------------------------------------------------------------
package hcmd_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 16;

  localparam logic [7:0]  DimVal     = 8'd23;
  localparam logic [15:0] HalfWheel  = 16'd32768;
  localparam logic [8:0]  FracOne    = 9'd256;
  localparam logic [2:0]  FadeSecs   = 3'd5;
  // floor(x / 5) == (x * Div5Recip) >> 18 for every x below 2^11
  localparam logic [15:0] Div5Recip  = 16'd52429;

  typedef logic [TimeBits-1:0] hcmd_time_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLowHue    = 3'd0,
    CfgLowSat    = 3'd1,
    CfgLowVal    = 3'd2,
    CfgHighHue   = 3'd3,
    CfgHighSat   = 3'd4,
    CfgHighVal   = 3'd5,
    CfgMotionVal = 3'd6,
    CfgHoldSecs  = 3'd7
  } hcmd_cfg_idx_e;

  typedef enum logic [1:0] {
    PhaseLowDim  = 2'd0,
    PhaseLowHigh = 2'd1,
    PhaseHighDim = 2'd2
  } hcmd_phase_e;

  typedef struct packed {
    logic [8:0]  blend;
    logic [1:0]  phase;
    logic        moving;
    logic [31:0] now_sec;
  } hcmd_in_t;

  typedef struct packed {
    logic [15:0] out_hue;
    logic [7:0]  out_sat;
    logic [7:0]  out_val;
  } hcmd_out_t;

  typedef struct packed {
    logic [15:0] low_hue;
    logic [7:0]  low_sat;
    logic [7:0]  low_val;
    logic [15:0] day_hue;
    logic [7:0]  high_sat;
    logic [7:0]  high_val;
    logic [7:0]  motion_bright;
    logic [15:0] hold_seconds;
  } hcmd_cfg_t;

  // (f * top + (1 - f) * bot) in 1/256 units, truncated
  function automatic logic [16:0] mix(input logic [8:0] f, input logic [16:0] top,
                                      input logic [16:0] bot);
    logic [25:0] acc;
    acc = 26'(f) * 26'(top) + 26'(FracOne - f) * 26'(bot);
    return acc[24:8];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'(Div5Recip);
    return prod[25:18];
  endfunction

endpackage

@@ rtl/core/hsv_crossfade_motion_dimmer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_crossfade_motion_dimmer_unit
// HSV crossfade between phase colours, with a motion-triggered dimmer.
// ----------------------------------------------------------------------------
// An input transaction passes the input register, then the result register;
//   throughput: one transaction per cycle while out_stall_i is low.
// The per-item path is set by the 9x17 hue multiply and the divide by five
//   in the motion fade, each between the input and result registers.
// Reset (rst_ni low, asynchronous) clears both valid flags, all
//   configuration registers and the first/last motion times.
// ----------------------------------------------------------------------------
module hsv_crossfade_motion_dimmer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [hcmd_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [hcmd_pkg::CfgBits-1:0]    cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hcmd_pkg::hcmd_in_t              in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hcmd_pkg::hcmd_out_t             out_data_o
);

  hcmd_pkg::hcmd_cfg_t  cfg;
  hcmd_pkg::hcmd_in_t   s1_q;
  hcmd_pkg::hcmd_out_t  out_q, out_d;
  logic                 s1_valid_q, out_valid_q;
  logic                 out_free, s1_fire, in_fire;
  logic [8:0]           frac;
  logic [15:0]          mix_hue;
  logic [7:0]           mix_sat, mix_val, mot_val;
  logic                 mark_first;

  hcmd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Result register frees up when empty or when its transaction leaves
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
  end

  // Saturate the blend fraction at 1.0
  assign frac = (s1_q.blend > hcmd_pkg::FracOne) ? hcmd_pkg::FracOne : s1_q.blend;

  // Phase zero below full blend restarts the first-motion mark
  assign mark_first = (s1_q.phase == hcmd_pkg::PhaseLowDim) && (frac != hcmd_pkg::FracOne);

  hcmd_blend u_blend (
    .frac_i  (frac),
    .phase_i (s1_q.phase),
    .cfg_i   (cfg),
    .hue_o   (mix_hue),
    .sat_o   (mix_sat),
    .val_o   (mix_val)
  );

  hcmd_motion u_motion (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .mark_first_i (mark_first),
    .moving_i     (s1_q.moving),
    .now_i        (hcmd_pkg::hcmd_time_t'(s1_q.now_sec)),
    .cfg_i        (cfg),
    .val_o        (mot_val)
  );

  // Motion lighting overrides the crossfade with the low colour
  always_comb begin
    if (s1_q.moving) begin
      out_d.out_hue = cfg.low_hue;
      out_d.out_sat = cfg.low_sat;
      out_d.out_val = mot_val;
    end else begin
      out_d.out_hue = mix_hue;
      out_d.out_sat = mix_sat;
      out_d.out_val = mix_val;
    end
  end

  // Stage 2: result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_in_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction missing from input register");

  a_s1_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("advanced transaction missing from result register");

  a_full_blend_high_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !s1_q.moving && (s1_q.phase == hcmd_pkg::PhaseLowHigh) &&
     (frac == hcmd_pkg::FracOne))
    |=> (out_q.out_hue == cfg.day_hue))
    else $error("full blend toward high colour did not give high hue");

endmodule

@@ rtl/core/hcmd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hcmd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hcmd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [hcmd_pkg::CfgBits-1:0]        cfg_data_i,
  output hcmd_pkg::hcmd_cfg_t                 cfg_o
);

  hcmd_pkg::hcmd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hcmd_pkg::CfgLowHue:    cfg_q.low_hue       <= cfg_data_i;
        hcmd_pkg::CfgLowSat:    cfg_q.low_sat       <= cfg_data_i[7:0];
        hcmd_pkg::CfgLowVal:    cfg_q.low_val       <= cfg_data_i[7:0];
        hcmd_pkg::CfgHighHue:   cfg_q.day_hue       <= cfg_data_i;
        hcmd_pkg::CfgHighSat:   cfg_q.high_sat      <= cfg_data_i[7:0];
        hcmd_pkg::CfgHighVal:   cfg_q.high_val      <= cfg_data_i[7:0];
        hcmd_pkg::CfgMotionVal: cfg_q.motion_bright <= cfg_data_i[7:0];
        hcmd_pkg::CfgHoldSecs:  cfg_q.hold_seconds  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/hcmd_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmd_blend
// Crossfade between the bottom and top colour of the selected phase.
// ----------------------------------------------------------------------------
module hcmd_blend (
  input  logic [8:0]          frac_i,
  input  logic [1:0]          phase_i,
  input  hcmd_pkg::hcmd_cfg_t cfg_i,
  output logic [15:0]         hue_o,
  output logic [7:0]          sat_o,
  output logic [7:0]          val_o
);

  logic [15:0] bot_hue, top_hue, diff;
  logic [7:0]  bot_sat, top_sat, bot_val, top_val;
  logic        wrap;
  logic [16:0] bot_hue_x, top_hue_x, hue_mix, sat_mix, val_mix;

  always_comb begin
    case (phase_i)
      hcmd_pkg::PhaseLowDim: begin
        bot_hue = cfg_i.low_hue;  top_hue = cfg_i.low_hue;
        bot_sat = cfg_i.low_sat;  top_sat = cfg_i.low_sat;
        bot_val = hcmd_pkg::DimVal;
        top_val = cfg_i.low_val;
      end
      hcmd_pkg::PhaseLowHigh: begin
        bot_hue = cfg_i.low_hue;  top_hue = cfg_i.day_hue;
        bot_sat = cfg_i.low_sat;  top_sat = cfg_i.high_sat;
        bot_val = cfg_i.low_val;  top_val = cfg_i.high_val;
      end
      default: begin
        bot_hue = cfg_i.day_hue;  top_hue = cfg_i.day_hue;
        bot_sat = cfg_i.high_sat; top_sat = cfg_i.high_sat;
        bot_val = cfg_i.high_val;
        top_val = hcmd_pkg::DimVal;
      end
    endcase
  end

  // Take the short way around the wheel: lift the smaller hue by a full turn
  assign diff      = (top_hue > bot_hue) ? (top_hue - bot_hue) : (bot_hue - top_hue);
  assign wrap      = (diff >= hcmd_pkg::HalfWheel);
  assign bot_hue_x = {wrap & ~bot_hue[15], bot_hue};
  assign top_hue_x = {wrap &  bot_hue[15], top_hue};

  assign hue_mix = hcmd_pkg::mix(frac_i, top_hue_x, bot_hue_x);
  assign sat_mix = hcmd_pkg::mix(frac_i, 17'(top_sat), 17'(bot_sat));
  assign val_mix = hcmd_pkg::mix(frac_i, 17'(top_val), 17'(bot_val));

  assign hue_o = hue_mix[15:0];
  assign sat_o = sat_mix[7:0];
  assign val_o = val_mix[7:0];

endmodule

@@ rtl/core/hcmd_motion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmd_motion
// Motion timestamps and the linear fade-in / fade-out brightness.
// ----------------------------------------------------------------------------
module hcmd_motion (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                mark_first_i,
  input  logic                moving_i,
  input  hcmd_pkg::hcmd_time_t now_i,
  input  hcmd_pkg::hcmd_cfg_t cfg_i,
  output logic [7:0]          val_o
);

  hcmd_pkg::hcmd_time_t first_q, first_d, last_q, last_d;
  hcmd_pkg::hcmd_time_t in_end, out_start, out_end, d_full, e_full;
  logic                 in_fade, out_fade;
  logic [2:0]           d, e, k;
  logic [10:0]          num;

  // Phase zero below full blend restarts the fade-in mark before the motion rule looks at it
  assign first_d   = mark_first_i ? now_i : first_q;
  assign in_end    = first_d + hcmd_pkg::hcmd_time_t'(hcmd_pkg::FadeSecs);
  assign out_start = last_q + hcmd_pkg::hcmd_time_t'(cfg_i.hold_seconds);
  assign out_end   = out_start + hcmd_pkg::hcmd_time_t'(hcmd_pkg::FadeSecs);
  assign in_fade   = (now_i < in_end);
  assign out_fade  = (now_i > out_start) && (now_i <= out_end);

  assign d_full = now_i - first_d;
  assign e_full = now_i - out_start;
  assign d = (d_full >= hcmd_pkg::hcmd_time_t'(hcmd_pkg::FadeSecs)) ? 3'd0 : d_full[2:0];
  assign e = (e_full > hcmd_pkg::hcmd_time_t'(hcmd_pkg::FadeSecs)) ?
             hcmd_pkg::FadeSecs : e_full[2:0];

  // Weight of motion_bright in fifths; the rest goes to low_val
  always_comb begin
    if (in_fade) begin
      k = d;
    end else if (out_fade) begin
      k = hcmd_pkg::FadeSecs - e;
    end else begin
      k = hcmd_pkg::FadeSecs;
    end
  end

  assign num   = 11'(k) * 11'(cfg_i.motion_bright)
               + 11'(hcmd_pkg::FadeSecs - k) * 11'(cfg_i.low_val);
  assign val_o = hcmd_pkg::div5(num);

  assign last_d = (moving_i && in_fade) ? now_i : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
    end else if (fire_i) begin
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  a_times_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(first_q) && $stable(last_q)))
    else $error("motion times changed without a transaction");

  a_last_idle_no_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !moving_i) |=> $stable(last_q))
    else $error("last motion time moved without motion");

  a_last_marks_fade_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && moving_i && in_fade) |=> (last_q == $past(now_i)))
    else $error("last motion time not marked during fade-in");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HSV crossfade and motion dimmer. A predictor in
// the bench tracks the register file and the first/last motion marks, works out
// the colour for every accepted input transaction and queues it. A checker pops
// the oldest colour for each result transaction and compares it field by field.
// Directed tests cover the blend extremes, the hue wrap and the motion fades;
// random tests cover many register settings and motion sequences. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FullWheel   = 65536;
  localparam logic [1:0]  PhaseSpare  = 2'd3;   // unnamed phase, acts as high-dim
  localparam int unsigned ReportLimit = 40;
  localparam int          CfgWidth    = $bits(hcmd_pkg::hcmd_cfg_t);
  localparam int          InWidth     = $bits(hcmd_pkg::hcmd_in_t);

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [hcmd_pkg::CfgIdxBits-1:0] cfg_idx_i   = '0;
  logic [hcmd_pkg::CfgBits-1:0]    cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  hcmd_pkg::hcmd_in_t              in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  hcmd_pkg::hcmd_out_t             out_data_o;

  // predictor state: shadow registers and motion marks
  hcmd_pkg::hcmd_cfg_t shadow_cfg;
  logic [31:0]         first_mark;
  logic [31:0]         last_mark;

  hcmd_pkg::hcmd_out_t pending_colours[$];
  int unsigned         fail_count;
  int unsigned         items_sent;

  // idle percentages, changed per test
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned stall_left;

  hsv_crossfade_motion_dimmer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int unsigned fade_mix(input int unsigned f, input int unsigned top,
                                           input int unsigned bot);
    return (f * top + (hcmd_pkg::FracOne - f) * bot) >> 8;
  endfunction

  // Work out the colour of one transaction and advance the motion marks.
  function automatic hcmd_pkg::hcmd_out_t predict_colour(input hcmd_pkg::hcmd_in_t item);
    int unsigned f, top_h, bot_h, top_s, bot_s, top_v, bot_v;
    int unsigned hue, sat, val, hue_span, step;
    logic [31:0] fade_in_end, out_start, out_end;
    hcmd_pkg::hcmd_out_t colour;
    f = (item.blend > hcmd_pkg::FracOne) ? hcmd_pkg::FracOne : item.blend;
    case (item.phase)
      hcmd_pkg::PhaseLowDim: begin
        bot_h = shadow_cfg.low_hue;  top_h = shadow_cfg.low_hue;
        bot_s = shadow_cfg.low_sat;  top_s = shadow_cfg.low_sat;
        bot_v = hcmd_pkg::DimVal;    top_v = shadow_cfg.low_val;
        // a partial blend in the low phase restarts the fade-in
        if (f != hcmd_pkg::FracOne) first_mark = item.now_sec;
      end
      hcmd_pkg::PhaseLowHigh: begin
        bot_h = shadow_cfg.low_hue;  top_h = shadow_cfg.day_hue;
        bot_s = shadow_cfg.low_sat;  top_s = shadow_cfg.high_sat;
        bot_v = shadow_cfg.low_val;  top_v = shadow_cfg.high_val;
      end
      default: begin
        bot_h = shadow_cfg.day_hue;  top_h = shadow_cfg.day_hue;
        bot_s = shadow_cfg.high_sat; top_s = shadow_cfg.high_sat;
        bot_v = shadow_cfg.high_val; top_v = hcmd_pkg::DimVal;
      end
    endcase

    if (item.moving) begin
      fade_in_end = first_mark + hcmd_pkg::FadeSecs;
      out_start   = last_mark + shadow_cfg.hold_seconds;
      out_end     = out_start + hcmd_pkg::FadeSecs;
      hue = shadow_cfg.low_hue;
      sat = shadow_cfg.low_sat;
      val = shadow_cfg.motion_bright;
      if (item.now_sec < fade_in_end) begin
        step = item.now_sec - first_mark;
        // before the first mark the fade has not begun
        if (step >= hcmd_pkg::FadeSecs) step = 0;
        val = (step * shadow_cfg.motion_bright
               + (hcmd_pkg::FadeSecs - step) * shadow_cfg.low_val) / hcmd_pkg::FadeSecs;
        last_mark = item.now_sec;
      end else if (item.now_sec > out_start && item.now_sec <= out_end) begin
        step = item.now_sec - out_start;
        if (step > hcmd_pkg::FadeSecs) step = hcmd_pkg::FadeSecs;
        val = (step * shadow_cfg.low_val
               + (hcmd_pkg::FadeSecs - step) * shadow_cfg.motion_bright) / hcmd_pkg::FadeSecs;
      end
    end else begin
      // hue goes the short way around the wheel
      hue_span = (top_h > bot_h) ? top_h - bot_h : bot_h - top_h;
      if (hue_span < hcmd_pkg::HalfWheel) hue = fade_mix(f, top_h, bot_h);
      else if (bot_h < hcmd_pkg::HalfWheel)
        hue = fade_mix(f, top_h, bot_h + FullWheel) % FullWheel;
      else hue = fade_mix(f, top_h + FullWheel, bot_h) % FullWheel;
      sat = fade_mix(f, top_s, bot_s);
      val = fade_mix(f, top_v, bot_v);
    end
    colour.out_hue = 16'(hue);
    colour.out_sat = 8'(sat);
    colour.out_val = 8'(val);
    return colour;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_colour(input hcmd_pkg::hcmd_out_t got);
    hcmd_pkg::hcmd_out_t want;
    if (pending_colours.size() == 0) begin
      report_mismatch($sformatf("colour %h with none expected", got));
      return;
    end
    want = pending_colours.pop_front();
    if (got.out_hue !== want.out_hue)
      report_mismatch($sformatf("hue %h, expected %h", got.out_hue, want.out_hue));
    if (got.out_sat !== want.out_sat)
      report_mismatch($sformatf("sat %h, expected %h", got.out_sat, want.out_sat));
    if (got.out_val !== want.out_val)
      report_mismatch($sformatf("val %h, expected %h", got.out_val, want.out_val));
  endtask

  function automatic int unsigned pick_pause();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: stall in random runs, check every transaction that goes through.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left  <= pick_pause() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall_i) check_colour(out_data_o);
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Send one transaction; valid stays high into the next call when no gap is drawn.
  task automatic send_item(input hcmd_pkg::hcmd_in_t item);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < in_gap_pct) ? pick_pause() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_colours.push_back(predict_colour(item));
    items_sent++;
  endtask

  task automatic send_fields(input logic [8:0] blend, input logic [1:0] phase,
                             input logic moving, input logic [31:0] now_sec);
    hcmd_pkg::hcmd_in_t item;
    item.blend   = blend;
    item.phase   = phase;
    item.moving  = moving;
    item.now_sec = now_sec;
    send_item(item);
  endtask

  // Drop valid and wait until every queued colour has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input hcmd_pkg::hcmd_cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      hcmd_pkg::CfgLowHue:    shadow_cfg.low_hue       = data;
      hcmd_pkg::CfgLowSat:    shadow_cfg.low_sat       = data[7:0];
      hcmd_pkg::CfgLowVal:    shadow_cfg.low_val       = data[7:0];
      hcmd_pkg::CfgHighHue:   shadow_cfg.day_hue       = data;
      hcmd_pkg::CfgHighSat:   shadow_cfg.high_sat      = data[7:0];
      hcmd_pkg::CfgHighVal:   shadow_cfg.high_val      = data[7:0];
      hcmd_pkg::CfgMotionVal: shadow_cfg.motion_bright = data[7:0];
      hcmd_pkg::CfgHoldSecs:  shadow_cfg.hold_seconds  = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the whole register file; junk in the upper byte of narrow registers.
  task automatic write_all(input hcmd_pkg::hcmd_cfg_t c);
    drain();
    write_reg(hcmd_pkg::CfgLowHue,    c.low_hue);
    write_reg(hcmd_pkg::CfgLowSat,    {8'($urandom), c.low_sat});
    write_reg(hcmd_pkg::CfgLowVal,    {8'($urandom), c.low_val});
    write_reg(hcmd_pkg::CfgHighHue,   c.day_hue);
    write_reg(hcmd_pkg::CfgHighSat,   {8'($urandom), c.high_sat});
    write_reg(hcmd_pkg::CfgHighVal,   {8'($urandom), c.high_val});
    write_reg(hcmd_pkg::CfgMotionVal, {8'($urandom), c.motion_bright});
    write_reg(hcmd_pkg::CfgHoldSecs,  c.hold_seconds);
  endtask

  function automatic hcmd_pkg::hcmd_cfg_t random_cfg();
    hcmd_pkg::hcmd_cfg_t c;
    c = hcmd_pkg::hcmd_cfg_t'(CfgWidth'({$urandom, $urandom, $urandom}));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_blend_extremes();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    // reset values first, then everything at its maximum
    send_fields(9'd0, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd0);
    write_all('1);
    send_fields(9'd0,   hcmd_pkg::PhaseLowDim,  1'b0, 32'hFFFF_FFFF);
    send_fields(9'd256, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd7);
    send_fields(9'd257, hcmd_pkg::PhaseHighDim, 1'b0, 32'd9);
    send_fields(9'd511, PhaseSpare,             1'b0, 32'd11);
    send_fields(9'd128, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd13);
  endtask

  task automatic test_hue_wrap();
    hcmd_pkg::hcmd_cfg_t c;
    in_gap_pct    = 30;
    out_stall_pct = 30;
    c = '{low_hue: 16'hF000, low_sat: 8'h10, low_val: 8'hF0, day_hue: 16'h1000,
          high_sat: 8'hE0, high_val: 8'h20, motion_bright: 8'h80, hold_seconds: 16'd2};
    write_all(c);   // wrap with the low hue in the upper half
    send_fields(9'd64,  hcmd_pkg::PhaseLowHigh, 1'b0, 32'd20);
    send_fields(9'd192, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd21);
    c.low_hue = 16'h0100;
    c.day_hue = 16'hFF00;
    write_all(c);   // wrap with the low hue in the lower half
    send_fields(9'd128, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd22);
    send_fields(9'd255, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd23);
    c.low_hue = 16'h0000;
    c.day_hue = 16'h8000;
    write_all(c);   // exactly half a turn apart
    send_fields(9'd1,   hcmd_pkg::PhaseLowHigh, 1'b0, 32'd24);
    send_fields(9'd200, hcmd_pkg::PhaseLowHigh, 1'b0, 32'd25);
  endtask

  task automatic test_motion_fade();
    hcmd_pkg::hcmd_cfg_t c;
    in_gap_pct    = 20;
    out_stall_pct = 20;
    c = '{low_hue: 16'h1234, low_sat: 8'h56, low_val: 8'd10, day_hue: 16'h9ABC,
          high_sat: 8'h78, high_val: 8'd200, motion_bright: 8'd250, hold_seconds: 16'd3};
    write_all(c);
    send_fields(9'd0,   hcmd_pkg::PhaseLowDim,  1'b0, 32'd1000);   // mark first motion
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd990);    // before the first mark
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1000);   // fade-in
    send_fields(9'd50,  hcmd_pkg::PhaseHighDim, 1'b1, 32'd1002);
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1004);
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1005);   // held at full
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1008);   // fade-out
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1010);
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1012);   // end of fade-out
    send_fields(9'd50,  hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1013);   // past the end
    send_fields(9'd256, hcmd_pkg::PhaseLowDim,  1'b1, 32'd2000);   // full blend keeps the mark
    send_fields(9'd100, hcmd_pkg::PhaseLowDim,  1'b1, 32'hFFFF_FFFE); // fade-in across wrap
    send_fields(9'd100, PhaseSpare,             1'b1, 32'hFFFF_FFFF);
    send_fields(9'd100, hcmd_pkg::PhaseLowHigh, 1'b1, 32'd1);
    send_fields(9'd100, hcmd_pkg::PhaseLowHigh, 1'b1, 32'd2);
  endtask

  task automatic test_random_colours();
    hcmd_pkg::hcmd_cfg_t c;
    hcmd_pkg::hcmd_in_t  item;
    for (int s = 0; s < 4; s++) begin
      if (s == 0) c = '0;
      else if (s == 1) c = '1;
      else c = random_cfg();
      write_all(c);
      in_gap_pct    = (s == 0) ? 0 : 20 * s;
      out_stall_pct = (s == 0) ? 0 : 80 - 20 * s;
      for (int i = 0; i < 100; i++) begin
        item = hcmd_pkg::hcmd_in_t'(InWidth'({$urandom, $urandom}));
        item.blend = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511))
                                                 : 9'($urandom_range(0, 256));
        send_item(item);
      end
    end
  endtask

  // Arm a fade-in, walk through it, then jump to the hold edge and walk the fade-out.
  task automatic test_motion_sequences();
    hcmd_pkg::hcmd_cfg_t c;
    hcmd_pkg::hcmd_in_t  item;
    logic [31:0]         base, now;
    for (int s = 0; s < 14; s++) begin
      c = random_cfg();
      case ($urandom_range(0, 4))
        0:       c.hold_seconds = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
        default: c.hold_seconds = 16'($urandom_range(0, 12));
      endcase
      write_all(c);
      in_gap_pct    = 25 * $urandom_range(0, 2);
      out_stall_pct = 25 * $urandom_range(0, 2);
      base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
      send_fields(9'($urandom_range(0, 255)), hcmd_pkg::PhaseLowDim,
                  1'($urandom_range(0, 1)), base);
      now = base - $urandom_range(0, 2);
      for (int k = 0; k < 20; k++) begin
        if (k == 8) now = base + c.hold_seconds + $urandom_range(0, 5);
        else now = now + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) begin
          // noise, possibly restarting the fade-in
          item = hcmd_pkg::hcmd_in_t'(InWidth'({$urandom, $urandom}));
          if ($urandom_range(0, 1) == 0) item.now_sec = now;
        end else begin
          item.moving  = 1'b1;
          item.now_sec = now;
          item.phase   = 2'($urandom_range(0, 3));
          item.blend   = (item.phase == hcmd_pkg::PhaseLowDim) ? 9'($urandom_range(256, 511))
                                                               : 9'($urandom_range(0, 511));
        end
        send_item(item);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_cfg    = '0;
    first_mark    = '0;
    last_mark     = '0;
    fail_count    = 0;
    items_sent    = 0;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    stall_left    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_blend_extremes();
    test_hue_wrap();
    test_motion_fade();
    test_random_colours();
    test_motion_sequences();

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_colours.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hold a hard limit on the run, far beyond the slowest legal schedule.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ hsv_crossfade_motion_dimmer_unit.f @@
rtl/core/hcmd_pkg.sv
rtl/core/hcmd_cfg_regs.sv
rtl/core/hcmd_blend.sv
rtl/core/hcmd_motion.sv
rtl/core/hsv_crossfade_motion_dimmer_unit.sv
test/testbench.sv
